FILE: sv/rpsd_pkg.sv
// Shared types and constants for the RGB pixel stream deframer.
package rpsd_pkg;

  // Item kinds carried on the input channel.
  typedef enum logic [1:0] {
    FUNC_BYTE      = 2'd0,
    FUNC_FRAME_END = 2'd1,
    FUNC_TICK      = 2'd2
  } func_t;

  // Position within a green, red, blue byte triple.
  typedef enum logic [2:0] {
    PH_GREEN = 3'b001,
    PH_RED   = 3'b010,
    PH_BLUE  = 3'b100
  } phase_t;

  localparam int unsigned COLOR_W   = 8;
  localparam int unsigned IDX_OUT_W = 16;
  localparam int unsigned IDLE_W    = 8;

  localparam logic [IDLE_W-1:0] GAP_LIMIT_RST = 8'd10;
  localparam logic [IDLE_W-1:0] IDLE_MAX      = 8'hFF;

  // Per-word context kept between items, apart from the LED counter.
  typedef struct packed {
    phase_t               phase;
    logic [COLOR_W-1:0]   green_hold;
    logic [COLOR_W-1:0]   red_hold;
    logic [IDLE_W-1:0]    idle_ms;
  } ctx_t;

  // One result word.
  typedef struct packed {
    logic                 pixel_valid;
    logic [IDX_OUT_W-1:0] led_index;
    logic [COLOR_W-1:0]   red;
    logic [COLOR_W-1:0]   green;
    logic [COLOR_W-1:0]   blue;
    logic                 frame_done;
    logic [IDX_OUT_W-1:0] frame_led_count;
  } result_t;

endpackage

FILE: sv/rpsd_step.sv
// Next-context and result logic for one input word of the deframer.
module rpsd_step #(
  parameter int unsigned INDEX_BITS = 16
) (
  input  rpsd_pkg::ctx_t                ctx_i,
  input  logic [INDEX_BITS-1:0]         cnt_i,
  input  logic [1:0]                    func_i,
  input  logic [rpsd_pkg::COLOR_W-1:0]  byte_i,
  input  logic [rpsd_pkg::IDLE_W-1:0]   gap_limit_i,
  output rpsd_pkg::ctx_t                ctx_o,
  output logic [INDEX_BITS-1:0]         cnt_o,
  output rpsd_pkg::result_t             res_o,
  output logic                          produced_o
);
  import rpsd_pkg::*;

  ctx_t                  base;
  logic [INDEX_BITS-1:0] base_cnt;

  // A gap longer than the limit restarts the frame before the byte is used.
  always_comb begin
    base     = ctx_i;
    base_cnt = cnt_i;
    if (ctx_i.idle_ms > gap_limit_i) begin
      base.phase      = PH_GREEN;
      base.green_hold = '0;
      base.red_hold   = '0;
      base_cnt        = '0;
    end
  end

  always_comb begin
    ctx_o      = ctx_i;
    cnt_o      = cnt_i;
    res_o      = '0;
    produced_o = 1'b0;
    case (func_i)
      FUNC_BYTE: begin
        ctx_o         = base;
        cnt_o         = base_cnt;
        ctx_o.idle_ms = '0;
        case (base.phase)
          PH_RED: begin
            ctx_o.red_hold = byte_i;
            ctx_o.phase    = PH_BLUE;
          end
          PH_BLUE: begin
            res_o.pixel_valid = 1'b1;
            res_o.led_index   = IDX_OUT_W'(base_cnt);
            res_o.red         = base.red_hold;
            res_o.green       = base.green_hold;
            res_o.blue        = byte_i;
            produced_o        = 1'b1;
            ctx_o.phase       = PH_GREEN;
            ctx_o.green_hold  = '0;
            ctx_o.red_hold    = '0;
            cnt_o             = base_cnt + 1'b1;
          end
          default: begin
            ctx_o.green_hold = byte_i;
            ctx_o.phase      = PH_RED;
          end
        endcase
      end
      FUNC_FRAME_END: begin
        res_o.frame_done      = 1'b1;
        res_o.frame_led_count = IDX_OUT_W'(cnt_i);
        produced_o            = 1'b1;
        ctx_o.phase           = PH_GREEN;
        cnt_o                 = '0;
      end
      FUNC_TICK: begin
        if (ctx_i.idle_ms != IDLE_MAX) begin
          ctx_o.idle_ms = ctx_i.idle_ms + 1'b1;
        end
      end
      default: begin
        // Unused kind: no change and no result.
      end
    endcase
  end

endmodule

FILE: sv/rgb_pixel_stream_deframer.sv
// Top level of the RGB pixel stream deframer: handshakes, context and result registers.
//
//   Channel  Direction  Handshake            Payload
//   in_      input      in_valid/in_ready    in_func, in_data_byte
//   out_     output     out_valid/out_ready  pixel and frame-end result fields
//   cfg_     input      cfg_valid/cfg_ready  cfg_gap_limit_ms
//
// Each word is decoded combinationally against the context registers, and
// its result, if any, lands in the output register at the edge that accepts the
// word, so a new word can be accepted every cycle unless the output stalls.
// Reset is synchronous and active low; it clears the context, the LED counter
// and the output valid, and loads the gap limit with 10 ms.
// The input stalls only while a result sits in the output register and the
// sink is not taking it. The configuration port is always ready.
module rgb_pixel_stream_deframer #(
  parameter int unsigned INDEX_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,

  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_func,
  input  logic [rpsd_pkg::COLOR_W-1:0]   in_data_byte,

  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_pixel_valid,
  output logic [rpsd_pkg::IDX_OUT_W-1:0] out_led_index,
  output logic [rpsd_pkg::COLOR_W-1:0]   out_red,
  output logic [rpsd_pkg::COLOR_W-1:0]   out_green,
  output logic [rpsd_pkg::COLOR_W-1:0]   out_blue,
  output logic                           out_frame_done,
  output logic [rpsd_pkg::IDX_OUT_W-1:0] out_frame_led_count,

  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rpsd_pkg::IDLE_W-1:0]    cfg_gap_limit_ms
);
  import rpsd_pkg::*;

  // Context carried from word to word, and the running LED counter, which
  // wraps at its own width.
  ctx_t                  ctx_r, ctx_nxt;
  logic [INDEX_BITS-1:0] cnt_r, cnt_nxt;
  logic [IDLE_W-1:0]     gap_limit_r, gap_limit_nxt;

  // Output register.
  logic                  out_valid_r, out_valid_nxt;
  result_t               res_r, res_nxt;

  ctx_t                  step_ctx;
  logic [INDEX_BITS-1:0] step_cnt;
  result_t               step_res;
  logic                  step_produced;
  logic                  in_fire;

  // The input may enter whenever the output register is empty or is being
  // drained in this same cycle.
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  rpsd_step #(
    .INDEX_BITS (INDEX_BITS)
  ) u_step (
    .ctx_i       (ctx_r),
    .cnt_i       (cnt_r),
    .func_i      (in_func),
    .byte_i      (in_data_byte),
    .gap_limit_i (gap_limit_r),
    .ctx_o       (step_ctx),
    .cnt_o       (step_cnt),
    .res_o       (step_res),
    .produced_o  (step_produced)
  );

  always_comb begin
    ctx_nxt       = ctx_r;
    cnt_nxt       = cnt_r;
    gap_limit_nxt = gap_limit_r;
    out_valid_nxt = out_valid_r;
    res_nxt       = res_r;

    if (cfg_valid) begin
      gap_limit_nxt = cfg_gap_limit_ms;
    end

    // Drain first, then a new result may refill the slot in the same cycle.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (in_fire) begin
      ctx_nxt = step_ctx;
      cnt_nxt = step_cnt;
      if (step_produced) begin
        out_valid_nxt = 1'b1;
        res_nxt       = step_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r.phase      <= PH_GREEN;
      ctx_r.green_hold <= '0;
      ctx_r.red_hold   <= '0;
      ctx_r.idle_ms    <= '0;
      cnt_r            <= '0;
      gap_limit_r      <= GAP_LIMIT_RST;
      out_valid_r      <= 1'b0;
    end else begin
      ctx_r       <= ctx_nxt;
      cnt_r       <= cnt_nxt;
      gap_limit_r <= gap_limit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload needs no reset; it is only looked at under out_valid.
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_pixel_valid     = res_r.pixel_valid;
  assign out_led_index       = res_r.led_index;
  assign out_red             = res_r.red;
  assign out_green           = res_r.green;
  assign out_blue            = res_r.blue;
  assign out_frame_done      = res_r.frame_done;
  assign out_frame_led_count = res_r.frame_led_count;

`ifndef SYNTHESIS
  // A held result is either a pixel or a frame end, never both or neither.
  a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pixel_valid != out_frame_done))
    else $error("result word is neither exactly a pixel nor a frame end");

  // An accepted frame end is presented next cycle and restarts the frame.
  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_func == FUNC_FRAME_END) |=>
      (out_valid && out_frame_done && cnt_r == '0 && ctx_r.phase == PH_GREEN))
    else $error("frame end did not produce a report and restart");

  // A tick never produces a result and never moves the byte phase.
  a_tick_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_func == FUNC_TICK) |=>
      ($stable(ctx_r.phase) && $stable(cnt_r) && !(out_valid && !$past(out_valid))))
    else $error("tick changed the frame state or raised a result");

  // A completed pixel word bumps the LED counter unless it was held at reset.
  a_pixel_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && step_produced && step_res.pixel_valid) |=>
      (cnt_r == $past(step_cnt) && ctx_r.phase == PH_GREEN))
    else $error("pixel completion did not advance the counter");
`endif

endmodule

FILE: test/rpsd_tb_pkg.sv
// Scoreboard class for the RGB pixel stream deframer testbench: predicts and checks result words.
package rpsd_tb_pkg;
  import rpsd_pkg::*;

  // The input channel can carry a fourth item kind that the block must ignore.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  class deframer_scoreboard;
    logic [IDLE_W-1:0]    gap_limit;
    phase_t               phase;
    logic [COLOR_W-1:0]   green_hold;
    logic [COLOR_W-1:0]   red_hold;
    logic [IDX_OUT_W-1:0] led_count;
    logic [IDLE_W-1:0]    idle_ms;
    result_t              pending_results[$];
    int unsigned          errors;

    function new();
      gap_limit  = GAP_LIMIT_RST;
      phase      = PH_GREEN;
      green_hold = '0;
      red_hold   = '0;
      led_count  = '0;
      idle_ms    = '0;
      errors     = 0;
    endfunction

    function void set_gap_limit(logic [IDLE_W-1:0] value);
      gap_limit = value;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // Advances the predicted state by one accepted word and queues its result, if any.
    function void note_word(logic [1:0] func, logic [COLOR_W-1:0] data);
      result_t pix;
      pix = '0;
      case (func)
        FUNC_BYTE: begin
          if (idle_ms > gap_limit) begin
            phase      = PH_GREEN;
            led_count  = '0;
            green_hold = '0;
            red_hold   = '0;
          end
          case (phase)
            PH_RED: begin
              red_hold = data;
              phase    = PH_BLUE;
            end
            PH_BLUE: begin
              pix.pixel_valid = 1'b1;
              pix.led_index   = led_count;
              pix.red         = red_hold;
              pix.green       = green_hold;
              pix.blue        = data;
              pending_results.push_back(pix);
              phase      = PH_GREEN;
              green_hold = '0;
              red_hold   = '0;
              led_count  = led_count + 1'b1;
            end
            default: begin
              green_hold = data;
              phase      = PH_RED;
            end
          endcase
          idle_ms = '0;
        end
        FUNC_FRAME_END: begin
          pix.frame_done      = 1'b1;
          pix.frame_led_count = led_count;
          pending_results.push_back(pix);
          phase     = PH_GREEN;
          led_count = '0;
        end
        FUNC_TICK: begin
          if (idle_ms != IDLE_MAX) idle_ms = idle_ms + 1'b1;
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task compare_field(string name, logic [IDX_OUT_W-1:0] got, logic [IDX_OUT_W-1:0] want);
      if (got !== want)
        report($sformatf("%s got 0x%h, expected 0x%h", name, got, want));
    endtask

    task check_word(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        report("result word arrived with no expectation pending");
        return;
      end
      want = pending_results.pop_front();
      compare_field("pixel_valid", IDX_OUT_W'(got.pixel_valid), IDX_OUT_W'(want.pixel_valid));
      compare_field("led_index", got.led_index, want.led_index);
      compare_field("red", IDX_OUT_W'(got.red), IDX_OUT_W'(want.red));
      compare_field("green", IDX_OUT_W'(got.green), IDX_OUT_W'(want.green));
      compare_field("blue", IDX_OUT_W'(got.blue), IDX_OUT_W'(want.blue));
      compare_field("frame_done", IDX_OUT_W'(got.frame_done), IDX_OUT_W'(want.frame_done));
      compare_field("frame_led_count", got.frame_led_count, want.frame_led_count);
    endtask
  endclass

endpackage

FILE: test/tb_rgb_pixel_stream_deframer.sv
// Testbench top for the RGB pixel stream deframer: directed and random words against a scoreboard.
module tb_rgb_pixel_stream_deframer;
  import rpsd_pkg::*;
  import rpsd_tb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The block registers every word's result at the edge that accepts it, so the settle
  // wait after the last expected result is plenty before touching the register.
  localparam int SETTLE_CYCLES = 4;
  // The limit sits well above what a correct run needs, even with every word
  // stalled as long as both sides allow.
  localparam int CYCLE_LIMIT = 100_000;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [1:0]           in_func;
  logic [COLOR_W-1:0]   in_data_byte;
  logic                 out_valid;
  logic                 out_ready;
  logic                 out_pixel_valid;
  logic [IDX_OUT_W-1:0] out_led_index;
  logic [COLOR_W-1:0]   out_red;
  logic [COLOR_W-1:0]   out_green;
  logic [COLOR_W-1:0]   out_blue;
  logic                 out_frame_done;
  logic [IDX_OUT_W-1:0] out_frame_led_count;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [IDLE_W-1:0]    cfg_gap_limit_ms;

  // Percent chance that a word (sender) or a cycle (receiver) starts an idle burst.
  int send_idle_pct;
  int recv_idle_pct;
  int cycle_count;

  deframer_scoreboard scoreboard = new();

  rgb_pixel_stream_deframer i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_func             (in_func),
    .in_data_byte        (in_data_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_pixel_valid     (out_pixel_valid),
    .out_led_index       (out_led_index),
    .out_red             (out_red),
    .out_green           (out_green),
    .out_blue            (out_blue),
    .out_frame_done      (out_frame_done),
    .out_frame_led_count (out_frame_led_count),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_gap_limit_ms    (cfg_gap_limit_ms)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // A hung handshake or a lost result ends here rather than running forever.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Every word that leaves the block is checked at the edge where it is taken.
  always @(posedge clk) begin : result_monitor
    result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.pixel_valid     = out_pixel_valid;
      got.led_index       = out_led_index;
      got.red             = out_red;
      got.green           = out_green;
      got.blue            = out_blue;
      got.frame_done      = out_frame_done;
      got.frame_led_count = out_frame_led_count;
      scoreboard.check_word(got);
    end
  end

  // The sink stalls in idle bursts whose length is drawn at random; with recv_idle_pct
  // at zero it takes a word every cycle.
  initial begin : sink_driver
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 99) < recv_idle_pct) begin
        stall = $urandom_range(1, 6);
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Offers one word and returns at the edge where it is accepted. The valid is
  // only lowered for an idle burst, so back-to-back words keep it high.
  task automatic send_word(input logic [1:0] func, input logic [COLOR_W-1:0] data);
    int gap;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_func      <= func;
    in_data_byte <= data;
    do @(posedge clk); while (!in_ready);
    scoreboard.note_word(func, data);
  endtask

  task automatic send_pixel(input logic [COLOR_W-1:0] g, input logic [COLOR_W-1:0] r,
                            input logic [COLOR_W-1:0] b);
    send_word(FUNC_BYTE, g);
    send_word(FUNC_BYTE, r);
    send_word(FUNC_BYTE, b);
  endtask

  task automatic send_ticks(input int count);
    repeat (count) send_word(FUNC_TICK, COLOR_W'($urandom));
  endtask

  // Holds the sender off until every expected result has come back, then lets
  // the block settle so a register write finds it idle.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (scoreboard.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_gap_limit(input logic [IDLE_W-1:0] value);
    @(negedge clk);
    cfg_valid        <= 1'b1;
    cfg_gap_limit_ms <= value;
    do @(posedge clk); while (!cfg_ready);
    scoreboard.set_gap_limit(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Tick bursts are mostly short, but under a small limit some land right at or
  // just past it so that both sides of the restart comparison are hit.
  function automatic int tick_burst_len();
    int limit;
    limit = int'(scoreboard.gap_limit);
    if (limit < 16 && $urandom_range(0, 2) == 0)
      return limit + int'($urandom_range(0, 2));
    return int'($urandom_range(1, 4));
  endfunction

  // Random traffic shaped like real frames: mostly whole pixel triples with
  // occasional ticks inside, plus frame ends, tick bursts, stray bytes that
  // break the triple alignment, and ignored words. The count covers bytes and
  // frame ends only.
  task automatic run_random(input int words);
    int sent;
    int pick;
    int n;
    sent = 0;
    while (sent < words) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        for (int k = 0; k < 3; k++) begin
          if ($urandom_range(0, 9) == 0) send_ticks($urandom_range(1, 3));
          send_word(FUNC_BYTE, COLOR_W'($urandom));
          sent++;
        end
      end else if (pick < 70) begin
        send_word(FUNC_FRAME_END, COLOR_W'($urandom));
        sent++;
      end else if (pick < 85) begin
        n = tick_burst_len();
        send_ticks(n);
      end else if (pick < 93) begin
        send_word(FUNC_BYTE, COLOR_W'($urandom));
        sent++;
      end else begin
        send_word(FUNC_UNUSED, COLOR_W'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_func          = FUNC_BYTE;
    in_data_byte     = '0;
    cfg_valid        = 1'b0;
    cfg_gap_limit_ms = GAP_LIMIT_RST;
    send_idle_pct    = 25;
    recv_idle_pct    = 25;
    cycle_count      = 0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, with the gap limit still at its reset value of 10 ms.
    // Extreme byte values, then an ignored word in the middle of a triple.
    send_pixel(8'h00, 8'hFF, 8'h01);
    send_pixel(8'hFF, 8'h00, 8'hFE);
    send_word(FUNC_BYTE, 8'h12);
    send_word(FUNC_UNUSED, 8'hFF);
    send_word(FUNC_BYTE, 8'h34);
    send_word(FUNC_BYTE, 8'h56);
    // A frame end with a partial triple pending drops the triple and reports three LEDs.
    send_word(FUNC_BYTE, 8'h77);
    send_word(FUNC_FRAME_END, 8'h00);
    // Exactly the limit of idle time keeps the frame going.
    send_pixel(8'h11, 8'h22, 8'h33);
    send_word(FUNC_BYTE, 8'h44);
    send_ticks(10);
    send_word(FUNC_BYTE, 8'h55);
    send_word(FUNC_BYTE, 8'h66);
    // One tick past the limit restarts the frame: the byte after becomes green of LED 0.
    send_word(FUNC_BYTE, 8'h88);
    send_ticks(11);
    send_pixel(8'h99, 8'hAA, 8'hBB);
    // A longer idle stretch restarts the frame as well.
    send_word(FUNC_BYTE, 8'hCC);
    send_ticks(20);
    send_pixel(8'hDD, 8'hEE, 8'h5A);
    send_word(FUNC_FRAME_END, 8'hFF);

    // The sender pauses for all results before every register write.
    wait_idle();
    write_gap_limit(8'd255);
    // At the top limit a saturated idle counter can never trigger a restart.
    send_pixel(8'h01, 8'h02, 8'h03);
    send_word(FUNC_BYTE, 8'h04);
    send_ticks(260);
    send_word(FUNC_BYTE, 8'h05);
    send_word(FUNC_BYTE, 8'h06);

    // The idle counter saturates at 255 rather than wrapping, so it still
    // exceeds a limit of 254 after a long idle stretch.
    wait_idle();
    write_gap_limit(8'd254);
    send_word(FUNC_BYTE, 8'h07);
    send_ticks(260);
    send_pixel(8'h08, 8'h09, 8'h0A);

    wait_idle();
    write_gap_limit(8'd0);
    // With a zero limit a single tick between bytes restarts the frame.
    send_word(FUNC_BYTE, 8'h0B);
    send_word(FUNC_TICK, 8'h00);
    send_pixel(8'h0C, 8'h0D, 8'h0E);
    send_word(FUNC_FRAME_END, 8'h00);

    // Random phases, each under its own gap limit and idling mix.
    run_random(50);
    wait_idle();
    write_gap_limit(8'd255);
    send_idle_pct = 50;
    recv_idle_pct = 10;
    run_random(50);

    wait_idle();
    write_gap_limit(8'd254);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(50);

    wait_idle();
    write_gap_limit(8'd3);
    send_idle_pct = 20;
    recv_idle_pct = 60;
    run_random(50);

    wait_idle();
    write_gap_limit(IDLE_W'($urandom_range(0, 20)));
    send_idle_pct = 40;
    recv_idle_pct = 40;
    run_random(50);

    wait_idle();
    write_gap_limit(IDLE_W'($urandom_range(1, 254)));
    send_idle_pct = 10;
    recv_idle_pct = 70;
    run_random(50);

    // Last part runs without idling on either side.
    wait_idle();
    write_gap_limit(GAP_LIMIT_RST);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(50);
    send_word(FUNC_FRAME_END, 8'h00);

    wait_idle();
    if (scoreboard.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
